// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the slotted page space manager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition at one edge implies a consequence at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

// ===== src/spsm_pkg.sv =====
// Package with the types, codes and page geometry of the slotted page space manager.
package spsm_pkg;

  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;
  localparam int SLOT_BYTES   = 8;
  localparam int MAX_SLOTS    = 512;

  localparam int ACT_W   = 3;
  localparam int SLOT_W  = 9;
  localparam int SIZE_W  = 13;
  localparam int STAT_W  = 2;
  localparam int USED_W  = $clog2(MAX_SLOTS + 1);
  localparam int CALC_W  = 16;

  localparam logic [ACT_W-1:0] ACT_INIT   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_DELETED = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot_id;
    logic [SIZE_W-1:0] rec_len;
  } spsm_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SIZE_W-1:0] byte_offset;
    logic [SIZE_W-1:0] out_size;
    logic [SLOT_W-1:0] assigned_slot;
  } spsm_out_t;

  typedef struct packed {
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] length;
    logic              tombstone;
  } spsm_entry_t;

endpackage

// ===== src/slotted_page_space_manager_core.sv =====
// Top level of the slotted page space manager: slot directory and free space bookkeeping.
//
//   Channel | Ports                          | Beat carries
//   --------+--------------------------------+------------------------------------------
//   in      | in_valid, in_ready, in_data    | action, slot_id, rec_len
//   out     | out_valid, out_ready, out_data | status, byte_offset, out_size, assigned_slot
//
// A command can be accepted every cycle while the output is not stalled. The accepting edge
// registers the command and its directory entry; the space checks and updates then run on
// that stage, and the result beat is registered when the stage advances.
// A directory write by one command is forwarded to the command right behind it.
// Reset empties the page at once; directory entries are written before they are read.
// A stalled result holds the pipeline, and in_ready follows out_ready.
`include "assert_macros.svh"

module slotted_page_space_manager_core
  import spsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  spsm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output spsm_out_t out_data
);

  localparam logic [CALC_W-1:0] HDR_C  = CALC_W'(HEADER_BYTES);
  localparam logic [CALC_W-1:0] SLOT_C = CALC_W'(SLOT_BYTES);
  localparam logic [CALC_W-1:0] MAX_C  = CALC_W'(MAX_SLOTS);
  localparam logic [SIZE_W-1:0] PAGE_C = SIZE_W'(PAGE_BYTES);

  spsm_entry_t dir_mem [MAX_SLOTS];

  spsm_in_t          s1_cmd_r;
  logic              s1_valid_r;
  spsm_entry_t       rd_data_r;
  spsm_out_t         out_data_r;
  logic              out_valid_r;
  logic [SIZE_W-1:0] free_pointer_r;
  logic [USED_W-1:0] used_slots_r;
  logic              fwd_valid_r;
  logic [SLOT_W-1:0] fwd_addr_r;
  spsm_entry_t       fwd_data_r;

  logic [SIZE_W-1:0] free_pointer_nxt;
  logic [USED_W-1:0] used_slots_nxt;
  spsm_out_t         out_data_nxt;

  logic              in_fire;
  logic              advance;
  logic              step;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  spsm_entry_t       mem_wdata;
  spsm_entry_t       entry_cur;
  logic [CALC_W-1:0] dir_end;
  logic [CALC_W-1:0] ins_need;
  logic [CALC_W-1:0] upd_need;
  logic [CALC_W-1:0] fp_ext;
  logic [CALC_W-1:0] size_ext;
  logic              in_range;
  logic [SIZE_W-1:0] fp_less;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;
  assign step     = s1_valid_r && advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign entry_cur = (fwd_valid_r && fwd_addr_r == s1_cmd_r.slot_id) ? fwd_data_r : rd_data_r;
  assign fp_ext    = CALC_W'(free_pointer_r);
  assign size_ext  = CALC_W'(s1_cmd_r.rec_len);
  assign dir_end   = HDR_C + CALC_W'(used_slots_r) * SLOT_C;
  assign ins_need  = dir_end + size_ext + SLOT_C;
  assign upd_need  = dir_end + size_ext;
  assign in_range  = CALC_W'(s1_cmd_r.slot_id) < CALC_W'(used_slots_r);
  assign fp_less   = free_pointer_r - s1_cmd_r.rec_len;

  always_comb begin
    free_pointer_nxt = free_pointer_r;
    used_slots_nxt   = used_slots_r;
    out_data_nxt     = '0;
    mem_we           = 1'b0;
    mem_waddr        = s1_cmd_r.slot_id;
    mem_wdata        = entry_cur;
    case (s1_cmd_r.action)
      ACT_INIT: begin
        free_pointer_nxt         = PAGE_C;
        used_slots_nxt           = '0;
        out_data_nxt.byte_offset = PAGE_C;
      end
      ACT_INSERT: begin
        if (CALC_W'(used_slots_r) >= MAX_C || fp_ext < ins_need) begin
          out_data_nxt.status = ST_NOSPACE;
        end else begin
          free_pointer_nxt           = fp_less;
          used_slots_nxt             = used_slots_r + USED_W'(1);
          mem_we                     = step;
          mem_waddr                  = used_slots_r[SLOT_W-1:0];
          mem_wdata.offset           = fp_less;
          mem_wdata.length           = s1_cmd_r.rec_len;
          mem_wdata.tombstone        = 1'b0;
          out_data_nxt.byte_offset   = fp_less;
          out_data_nxt.out_size      = s1_cmd_r.rec_len;
          out_data_nxt.assigned_slot = used_slots_r[SLOT_W-1:0];
        end
      end
      ACT_GET: begin
        if (!in_range) begin
          out_data_nxt.status = ST_RANGE;
        end else if (entry_cur.tombstone) begin
          out_data_nxt.status = ST_DELETED;
        end else begin
          out_data_nxt.byte_offset = entry_cur.offset;
          out_data_nxt.out_size    = entry_cur.length;
        end
      end
      ACT_UPDATE: begin
        if (!in_range) begin
          out_data_nxt.status = ST_RANGE;
        end else if (entry_cur.tombstone) begin
          out_data_nxt.status = ST_DELETED;
        end else if (s1_cmd_r.rec_len <= entry_cur.length) begin
          mem_we                   = step;
          mem_wdata.length         = s1_cmd_r.rec_len;
          out_data_nxt.byte_offset = entry_cur.offset;
          out_data_nxt.out_size    = s1_cmd_r.rec_len;
        end else if (fp_ext < upd_need) begin
          out_data_nxt.status      = ST_NOSPACE;
          out_data_nxt.byte_offset = entry_cur.offset;
          out_data_nxt.out_size    = entry_cur.length;
        end else begin
          free_pointer_nxt         = fp_less;
          mem_we                   = step;
          mem_wdata.offset         = fp_less;
          mem_wdata.length         = s1_cmd_r.rec_len;
          out_data_nxt.byte_offset = fp_less;
          out_data_nxt.out_size    = s1_cmd_r.rec_len;
        end
      end
      ACT_DELETE: begin
        if (!in_range) begin
          out_data_nxt.status = ST_RANGE;
        end else begin
          mem_we              = step;
          mem_wdata.tombstone = 1'b1;
        end
      end
      default: begin
        out_data_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dir_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_data_r <= dir_mem[in_data.slot_id];
      s1_cmd_r  <= in_data;
    end
    if (step) begin
      out_data_r <= out_data_nxt;
    end
    if (mem_we) begin
      fwd_addr_r <= mem_waddr;
      fwd_data_r <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      free_pointer_r <= PAGE_C;
      used_slots_r   <= '0;
      fwd_valid_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (step) begin
        free_pointer_r <= free_pointer_nxt;
        used_slots_r   <= used_slots_nxt;
      end
      if (mem_we) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_slots_bounded, clk, rst_n, CALC_W'(used_slots_r) <= MAX_C, "slot count above the directory size")
  `ASSERT_CLK(a_gap_nonneg, clk, rst_n, fp_ext >= dir_end, "free pointer below the end of the directory")
  `ASSERT_CLK(a_ready_follows, clk, rst_n, out_ready |-> in_ready, "input stalled while the output drains")
  `ASSERT_NEXT(a_insert_count, clk, rst_n, step && s1_cmd_r.action == ACT_INSERT && out_data_nxt.status == ST_OK, used_slots_r == $past(used_slots_r) + USED_W'(1), "successful insert did not add a slot")

endmodule
